// ----- rtl/kht_pkg.sv -----
// Package for the killer move and history table.
// Holds the table sizes, limits and state codes; used by killer_and_history_table.
`default_nettype none
package kht_pkg;

  localparam int unsigned HEIGHT_SLOTS    = 256;
  localparam int unsigned KILL_AW         = $clog2(HEIGHT_SLOTS);
  localparam int unsigned HISTORY_ENTRIES = 768;
  localparam int unsigned HIST_AW         = 10;
  localparam int unsigned CNT_W           = 14;
  localparam int unsigned MOVE_W          = 16;
  localparam int unsigned RATIO_STEPS     = 14;

  localparam logic [14:0] LIMIT_MAX  = 15'd16384;
  localparam logic [14:0] LIMIT_MIN  = 15'd2;
  localparam logic [15:0] QUIET_BASE = 16'hA240; // -24000
  localparam logic [3:0]  KIND_MAX   = 4'd11;

  localparam logic [1:0] FUNC_CUTOFF = 2'd0;
  localparam logic [1:0] FUNC_HIT    = 2'd1;
  localparam logic [1:0] FUNC_MISS   = 2'd2;
  localparam logic [1:0] FUNC_LOOKUP = 2'd3;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] weight;
    logic [CNT_W-1:0] hit;
    logic [CNT_W-1:0] total;
  } hist_word_t;

endpackage
`default_nettype wire

// ----- rtl/killer_and_history_table.sv -----
// Killer move pairs per search height and a history table with hit/total counters.
// Depends on kht_pkg for sizes, codes and the memory word layout.
// Each request passes through MOD, an optional WALK, the 14-step divider (DIV) and OUT.
// Requests are taken only in IDLE; busy stays high until done. A cutoff that reaches the limit halves every weight.
// Reset: a clearing pass through all 768 history entries (killers cleared alongside);
// busy is high during it. The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none
module killer_and_history_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [14:0] cfg_data_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] move_code_i,
  input  wire logic        is_tactical_i,
  input  wire logic [3:0]  piece_kind_i,
  input  wire logic [5:0]  to_square_i,
  input  wire logic [5:0]  search_depth_i,
  input  wire logic [7:0]  ply_height_i,
  output logic             done_o,
  output logic [15:0]      killer_first_o,
  output logic [15:0]      killer_second_o,
  output logic [13:0]      history_count_o,
  output logic signed [15:0] quiet_score_o,
  output logic [14:0]      success_ratio_o
);

  kht_pkg::state_e state_q, state_d;

  logic [14:0] limit_q;
  logic [14:0] lim;

  // captured item
  logic [1:0]                   func_q;
  logic [kht_pkg::MOVE_W-1:0]   move_q;
  logic                         upd_q;
  logic [kht_pkg::HIST_AW-1:0]  ent_q;
  logic [kht_pkg::KILL_AW-1:0]  hgt_q;
  logic [5:0]                   depth_q;

  // memories
  logic [2*kht_pkg::MOVE_W-1:0] kmem [kht_pkg::HEIGHT_SLOTS];
  kht_pkg::hist_word_t          hmem [kht_pkg::HISTORY_ENTRIES];
  logic [2*kht_pkg::MOVE_W-1:0] k_rd_q, k_wd;
  kht_pkg::hist_word_t          h_rd_q, h_wd;
  logic                         k_we, h_we;
  logic [kht_pkg::KILL_AW-1:0]  k_wa, k_ra;
  logic [kht_pkg::HIST_AW-1:0]  h_wa, h_ra;

  // sweep / walk
  logic [kht_pkg::HIST_AW-1:0]  cnt_q;
  logic                         wv_q;
  logic [kht_pkg::HIST_AW-1:0]  wa_q;
  logic [14:0]                  wfull_q;

  // results and divider
  logic [2*kht_pkg::MOVE_W-1:0] kill_q;
  logic [13:0]                  weight_q;
  logic [13:0]                  den_q;
  logic [13:0]                  rem_q;
  logic [14:0]                  quo_q;
  logic [3:0]                   step_q;

  logic [3:0]                   kind_c;
  logic [kht_pkg::HIST_AW-1:0]  ent_c;
  logic                         accept;

  // modify-stage terms
  logic [11:0] dsq;
  logic [14:0] wsum;
  logic [14:0] hit1, tot1;
  logic [13:0] hitn, totn;
  logic        age_cut, age_pair;
  logic [14:0] whalf_src;
  logic [13:0] whalf;
  logic [14:0] r2;

  always_comb begin
    if (limit_q < kht_pkg::LIMIT_MIN) begin
      lim = kht_pkg::LIMIT_MIN;
    end else if (limit_q > kht_pkg::LIMIT_MAX) begin
      lim = kht_pkg::LIMIT_MAX;
    end else begin
      lim = limit_q;
    end
  end

  assign accept = start_i && (state_q == kht_pkg::ST_IDLE);
  assign busy_o = (state_q != kht_pkg::ST_IDLE);
  assign kind_c = (piece_kind_i > kht_pkg::KIND_MAX) ? kht_pkg::KIND_MAX : piece_kind_i;
  assign ent_c  = {kind_c, to_square_i};

  assign dsq  = depth_q * depth_q;
  assign wsum = {1'b0, h_rd_q.weight} + {3'b0, dsq};
  assign hit1 = {1'b0, h_rd_q.hit} + ((func_q == kht_pkg::FUNC_HIT) ? 15'd1 : 15'd0);
  assign tot1 = {1'b0, h_rd_q.total} + 15'd1;
  assign age_pair = (tot1 >= lim);
  assign hitn = age_pair ? 14'((hit1 + 15'd1) >> 1) : hit1[13:0];
  assign totn = age_pair ? 14'((tot1 + 15'd1) >> 1) : tot1[13:0];
  assign age_cut = upd_q && (func_q == kht_pkg::FUNC_CUTOFF) && (wsum >= lim);

  assign whalf_src = (wa_q == ent_q) ? wfull_q : {1'b0, h_rd_q.weight};
  assign whalf     = 14'((16'(whalf_src) + 16'd1) >> 1);
  assign r2        = {rem_q, 1'b0};

  // memory port control
  always_comb begin
    k_we = 1'b0;
    k_wa = hgt_q;
    k_wd = '0;
    h_we = 1'b0;
    h_wa = ent_q;
    h_wd = h_rd_q;
    k_ra = ply_height_i[kht_pkg::KILL_AW-1:0];
    h_ra = ent_c;
    case (state_q)
      kht_pkg::ST_CLEAR: begin
        h_we = 1'b1;
        h_wa = cnt_q;
        h_wd = '{weight: '0, hit: 14'd1, total: 14'd1};
        k_we = (10'(cnt_q) < 10'(kht_pkg::HEIGHT_SLOTS));
        k_wa = cnt_q[kht_pkg::KILL_AW-1:0];
      end
      kht_pkg::ST_MOD: begin
        if (upd_q && (func_q == kht_pkg::FUNC_CUTOFF)) begin
          k_we = (k_rd_q[31:16] != move_q);
          k_wd = {move_q, k_rd_q[31:16]};
          h_we = !age_cut;
          h_wd = '{weight: wsum[13:0], hit: h_rd_q.hit, total: h_rd_q.total};
        end else if (upd_q) begin
          h_we = 1'b1;
          h_wd = '{weight: h_rd_q.weight, hit: hitn, total: totn};
        end
      end
      kht_pkg::ST_WALK: begin
        h_ra = cnt_q;
        h_we = wv_q;
        h_wa = wa_q;
        h_wd = '{weight: whalf, hit: h_rd_q.hit, total: h_rd_q.total};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (k_we) begin
      kmem[k_wa] <= k_wd;
    end
    k_rd_q <= kmem[k_ra];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    h_rd_q <= hmem[h_ra];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kht_pkg::ST_CLEAR: begin
        if (10'(cnt_q) == 10'(kht_pkg::HISTORY_ENTRIES - 1)) state_d = kht_pkg::ST_IDLE;
      end
      kht_pkg::ST_IDLE: begin
        if (accept) state_d = kht_pkg::ST_MOD;
      end
      kht_pkg::ST_MOD: begin
        state_d = age_cut ? kht_pkg::ST_WALK : kht_pkg::ST_DIV;
      end
      kht_pkg::ST_WALK: begin
        if (wv_q && (10'(wa_q) == 10'(kht_pkg::HISTORY_ENTRIES - 1))) begin
          state_d = kht_pkg::ST_DIV;
        end
      end
      kht_pkg::ST_DIV: begin
        if (step_q == 4'(kht_pkg::RATIO_STEPS - 1)) state_d = kht_pkg::ST_OUT;
      end
      kht_pkg::ST_OUT: begin
        state_d = kht_pkg::ST_IDLE;
      end
      default: begin
        state_d = kht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kht_pkg::ST_CLEAR;
      limit_q <= kht_pkg::LIMIT_MAX;
      cnt_q   <= '0;
      wv_q    <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      case (state_q)
        kht_pkg::ST_CLEAR: begin
          cnt_q <= cnt_q + 10'd1;
        end
        kht_pkg::ST_MOD: begin
          cnt_q  <= '0;
          wv_q   <= 1'b0;
          step_q <= '0;
        end
        kht_pkg::ST_WALK: begin
          // read entry cnt, write back the entry read just before it (address held in wa_q)
          wv_q <= (10'(cnt_q) < 10'(kht_pkg::HISTORY_ENTRIES));
          if (10'(cnt_q) < 10'(kht_pkg::HISTORY_ENTRIES)) begin
            cnt_q <= cnt_q + 10'd1;
          end
        end
        kht_pkg::ST_DIV: begin
          step_q <= step_q + 4'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      move_q  <= move_code_i;
      upd_q   <= !is_tactical_i && (move_code_i != '0) && (func_i != kht_pkg::FUNC_LOOKUP);
      ent_q   <= ent_c;
      hgt_q   <= ply_height_i[kht_pkg::KILL_AW-1:0];
      depth_q <= search_depth_i;
    end
    case (state_q)
      kht_pkg::ST_MOD: begin
        wfull_q <= wsum;
        if (upd_q && (func_q == kht_pkg::FUNC_CUTOFF) && (k_rd_q[31:16] != move_q)) begin
          kill_q <= {move_q, k_rd_q[31:16]};
        end else begin
          kill_q <= k_rd_q;
        end
        if (upd_q && (func_q == kht_pkg::FUNC_CUTOFF)) begin
          weight_q <= wsum[13:0];
          den_q    <= h_rd_q.total;
          rem_q    <= h_rd_q.hit;
        end else if (upd_q) begin
          weight_q <= h_rd_q.weight;
          den_q    <= totn;
          rem_q    <= hitn;
        end else begin
          weight_q <= h_rd_q.weight;
          den_q    <= h_rd_q.total;
          rem_q    <= h_rd_q.hit;
        end
        quo_q <= '0;
      end
      kht_pkg::ST_WALK: begin
        if (wv_q && (wa_q == ent_q)) begin
          weight_q <= whalf;
        end
        wa_q <= cnt_q;
      end
      kht_pkg::ST_DIV: begin
        if (step_q == '0 && (rem_q >= den_q)) begin
          // ratio of one or more saturates
          quo_q  <= 15'd16384;
          rem_q  <= '0;
          den_q  <= 14'h3FFF;
        end else if (quo_q[14]) begin
          quo_q <= quo_q;
        end else if (r2 >= {1'b0, den_q}) begin
          rem_q <= 14'(r2 - {1'b0, den_q});
          quo_q <= {quo_q[13:0], 1'b1};
        end else begin
          rem_q <= r2[13:0];
          quo_q <= {quo_q[13:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign done_o          = (state_q == kht_pkg::ST_OUT);
  assign killer_first_o  = kill_q[31:16];
  assign killer_second_o = kill_q[15:0];
  assign history_count_o = weight_q;
  assign quiet_score_o   = $signed(kht_pkg::QUIET_BASE + {2'b00, weight_q});
  assign success_ratio_o = quo_q;

endmodule
`default_nettype wire
